>>> rtl/ilst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_pkg: shared definitions for the indexed list store
// Field widths, action codes and status codes of the request and response.
// ----------------------------------------------------------------------------
package ilst_pkg;

   localparam int ACTION_W = 4;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic [ACTION_W-1:0] ACT_ADD_BACK   = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD_FRONT  = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_RM_FRONT   = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_RM_BACK    = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK_FRONT = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_PEEK_BACK  = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_PEEK_AT    = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_INSERT_AT  = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_RM_AT      = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_REPLACE_AT = 4'd9;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd10;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

endpackage

>>> rtl/ilst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_ram: element storage of the indexed list store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ilst_ram #(
   parameter int   DEPTH  = 64,
   parameter int   WIDTH  = 32,
   localparam int  ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/indexed_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store: bounded ordered list of words held in a RAM
// Add, remove, peek, insert, replace and clear; each request returns one
// response with read data, the new length and a status.
//
//   channel   ports                                      transfer
//   request   start, busy, req_action/position/data_in   start & !busy
//   response  rsp_valid, rsp_data_out/length/status      rsp_valid (1 cycle)
//
// Add back, remove back, replace, clear and every error respond in the
// cycle after the request. Peeks respond from the peek state, after the registered RAM read.
// Add front, remove front, insert and remove at a position move the
// elements behind the position one per cycle through the single RAM port
// pair, at most DEPTH - 1 of them, and respond once the last move and, for
// add front and insert, the write of the new word are done.
// Synchronous reset empties the list; the RAM contents are not cleared.
// The response cannot be stalled; busy holds off requests during peeks and moves.
// ----------------------------------------------------------------------------
module indexed_list_store #(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ilst_pkg::ACTION_W-1:0] req_action,
   input  logic [ilst_pkg::POS_W-1:0]    req_position,
   input  logic [ilst_pkg::DATA_W-1:0]   req_data_in,
   output logic                          rsp_valid,
   output logic [ilst_pkg::DATA_W-1:0]   rsp_data_out,
   output logic [ilst_pkg::LEN_W-1:0]    rsp_length,
   output logic [ilst_pkg::STATUS_W-1:0] rsp_status
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > ilst_pkg::POS_W) ? CW : ilst_pkg::POS_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PEEK  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;

   logic [1:0]                    state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 cur_ff, cur_in;
   logic [AW-1:0]                 last_ff, last_in;
   logic                          issue_ff, issue_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 wa_ff, wa_in;
   logic                          open_ff, open_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [ELEM_WIDTH-1:0]         word_ff, word_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ilst_pkg::DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [ilst_pkg::LEN_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [ilst_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ELEM_WIDTH-1:0] rd_data;

   logic            is_full;
   logic            is_empty;
   logic            pos_bad;
   logic [CMPW-1:0] pos_ext;
   logic [CMPW-1:0] cnt_ext;

   ilst_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ELEM_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign pos_ext  = CMPW'(req_position);
   assign cnt_ext  = CMPW'(count_ff);
   assign pos_bad  = (pos_ext >= cnt_ext);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      cur_in        = cur_ff;
      last_in       = last_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      wa_in         = wa_ff;
      open_in       = open_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = '0;
      rsp_length_in = rsp_length_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = wa_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_status_in = ilst_pkg::STAT_OK;
               rsp_valid_in  = 1'b1;
               word_in       = ELEM_WIDTH'(req_data_in);
               pos_in        = AW'(req_position);
               unique case (req_action)
                  ilst_pkg::ACT_ADD_BACK: begin
                     if (is_full) begin
                        rsp_status_in = ilst_pkg::STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(count_ff);
                        wr_data  = ELEM_WIDTH'(req_data_in);
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ilst_pkg::ACT_ADD_FRONT: begin
                     if (is_full) begin
                        rsp_status_in = ilst_pkg::STAT_FULL;
                     end else begin
                        count_in     = count_ff + CW'(1);
                        open_in      = 1'b1;
                        pos_in       = '0;
                        issue_in     = !is_empty;
                        cur_in       = AW'(count_ff - CW'(1));
                        last_in      = '0;
                        rsp_valid_in = 1'b0;
                        state_in     = S_SHIFT;
                     end
                  end
                  ilst_pkg::ACT_RM_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = ilst_pkg::STAT_EMPTY;
                     end else begin
                        count_in     = count_ff - CW'(1);
                        open_in      = 1'b0;
                        issue_in     = (count_ff != CW'(1));
                        cur_in       = AW'(1);
                        last_in      = AW'(count_ff - CW'(1));
                        rsp_valid_in = 1'b0;
                        state_in     = S_SHIFT;
                     end
                  end
                  ilst_pkg::ACT_RM_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = ilst_pkg::STAT_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  ilst_pkg::ACT_PEEK_FRONT: begin
                     if (is_empty) begin
                        rsp_status_in = ilst_pkg::STAT_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        rsp_valid_in = 1'b0;
                        state_in     = S_PEEK;
                     end
                  end
                  ilst_pkg::ACT_PEEK_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = ilst_pkg::STAT_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = AW'(count_ff - CW'(1));
                        rsp_valid_in = 1'b0;
                        state_in     = S_PEEK;
                     end
                  end
                  ilst_pkg::ACT_PEEK_AT: begin
                     if (pos_bad) begin
                        rsp_status_in = ilst_pkg::STAT_RANGE;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = AW'(req_position);
                        rsp_valid_in = 1'b0;
                        state_in     = S_PEEK;
                     end
                  end
                  ilst_pkg::ACT_INSERT_AT: begin
                     if (is_full) begin
                        rsp_status_in = ilst_pkg::STAT_FULL;
                     end else if (pos_bad) begin
                        rsp_status_in = ilst_pkg::STAT_RANGE;
                     end else begin
                        count_in     = count_ff + CW'(1);
                        open_in      = 1'b1;
                        issue_in     = 1'b1;
                        cur_in       = AW'(count_ff - CW'(1));
                        last_in      = AW'(req_position);
                        rsp_valid_in = 1'b0;
                        state_in     = S_SHIFT;
                     end
                  end
                  ilst_pkg::ACT_RM_AT: begin
                     if (pos_bad) begin
                        rsp_status_in = ilst_pkg::STAT_RANGE;
                     end else begin
                        count_in     = count_ff - CW'(1);
                        open_in      = 1'b0;
                        issue_in     = ((pos_ext + CMPW'(1)) != cnt_ext);
                        cur_in       = AW'(req_position) + AW'(1);
                        last_in      = AW'(count_ff - CW'(1));
                        rsp_valid_in = 1'b0;
                        state_in     = S_SHIFT;
                     end
                  end
                  ilst_pkg::ACT_REPLACE_AT: begin
                     if (pos_bad) begin
                        rsp_status_in = ilst_pkg::STAT_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_position);
                        wr_data = ELEM_WIDTH'(req_data_in);
                     end
                  end
                  ilst_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
               rsp_length_in = ilst_pkg::LEN_W'(count_in);
            end
         end
         S_PEEK: begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = ilst_pkg::DATA_W'(rd_data);
            rsp_status_in = ilst_pkg::STAT_OK;
            rsp_length_in = ilst_pkg::LEN_W'(count_ff);
            state_in      = S_IDLE;
         end
         S_SHIFT: begin
            rd_en    = issue_ff;
            rd_addr  = cur_ff;
            wr_en    = pend_ff;
            wr_addr  = wa_ff;
            wr_data  = rd_data;
            pend_in  = issue_ff;
            wa_in    = open_ff ? (cur_ff + AW'(1)) : (cur_ff - AW'(1));
            issue_in = issue_ff && (cur_ff != last_ff);
            cur_in   = open_ff ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));
            if (!issue_ff && !pend_ff) begin
               if (open_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = pos_ff;
                  wr_data = word_ff;
               end
               rsp_valid_in  = 1'b1;
               rsp_status_in = ilst_pkg::STAT_OK;
               rsp_length_in = ilst_pkg::LEN_W'(count_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         issue_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      last_ff       <= last_in;
      wa_ff         <= wa_in;
      open_ff       <= open_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_length_ff <= rsp_length_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_status   = rsp_status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("Element count exceeds the list depth.");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("Accepted request neither responded nor started work.");

   a_shift_no_clash: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT && wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("Element move reads and writes the same entry.");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ilst_pkg::STAT_FULL) |-> (count_ff == CW'(DEPTH)))
      else $error("Full status reported while the list has room.");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ilst_pkg::STAT_EMPTY) |-> (rsp_length == '0))
      else $error("Empty status reported with a nonzero length.");

endmodule
